// ----- rtl/phbl_pkg.sv -----
`default_nettype none
package phbl_pkg;

  localparam int HASH_W = 37;
  localparam int CH_W   = 7;   // base 128 = 2^CH_W, so one doubling per byte bit

  localparam logic [HASH_W-1:0] HASH_MOD = 37'd99999999977;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  // Reduce a value below 3 * HASH_MOD into 0 .. HASH_MOD-1.
  function automatic logic [HASH_W-1:0] mod_red3(input logic [HASH_W+1:0] x);
    logic [HASH_W+1:0] p1;
    logic [HASH_W+1:0] p2;
    logic [HASH_W+1:0] r;
    p1 = {2'b00, HASH_MOD};
    p2 = {1'b0, HASH_MOD, 1'b0};
    if (x >= p2) begin
      r = x - p2;
    end else if (x >= p1) begin
      r = x - p1;
    end else begin
      r = x;
    end
    return r[HASH_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/phbl_ram.sv -----
`default_nettype none
module phbl_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/phbl_queue.sv -----
`default_nettype none
module phbl_queue #(
  parameter int WIDTH = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  // Two-entry FIFO.
  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_data;
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/phbl_front.sv -----
`default_nettype none
module phbl_front #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int FW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [1:0]                    kind,
  input  wire logic [phbl_pkg::CH_W-1:0]     byte_value,
  input  wire logic [phbl_pkg::HASH_W-1:0]   entry_hash,
  output logic                               busy,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic      [phbl_pkg::HASH_W-1:0]   q_hash,
  output logic      [FW-1:0]                 q_count,
  output logic                               tw_en,
  output logic      [AW-1:0]                 tw_addr,
  output logic      [phbl_pkg::HASH_W-1:0]   tw_data
);
  import phbl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_FIN} state_t;

  state_t            state;
  logic [HASH_W-1:0] run_hash;
  logic [HASH_W-1:0] run_power;
  logic [HASH_W-1:0] term;
  logic [HASH_W-1:0] pw;
  logic [CH_W-1:0]   ch;
  logic [2:0]        step;
  logic [FW-1:0]     fill;

  logic              accept;
  logic              table_full;
  logic [HASH_W-1:0] term_next;
  logic [HASH_W-1:0] pw_next;
  logic [HASH_W-1:0] sum_next;

  assign busy       = (state != S_IDLE) || q_full;
  assign accept     = start && !busy;
  assign table_full = (fill == FW'(TABLE_DEPTH));

  assign tw_en   = accept && (kind_t'(kind) == KIND_LOAD) && !table_full;
  assign tw_addr = fill[AW-1:0];
  assign tw_data = entry_hash;

  // End of string hands the finished hash and the current fill to the back end.
  assign q_push  = accept && (kind_t'(kind) == KIND_END);
  assign q_hash  = run_hash;
  assign q_count = fill;

  // Shift-add modular multiply, byte MSB first; power doubles alongside.
  assign term_next = mod_red3({1'b0, term, 1'b0} + (ch[CH_W-1] ? {2'b00, run_power} : '0));
  assign pw_next   = mod_red3({1'b0, pw, 1'b0});
  assign sum_next  = mod_red3({2'b00, run_hash} + {2'b00, term});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run_hash  <= '0;
      run_power <= HASH_W'(1);
      fill      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (kind_t'(kind))
              KIND_LOAD: begin
                if (!table_full) begin
                  fill <= fill + FW'(1);
                end
              end
              KIND_BYTE: begin
                ch    <= byte_value;
                term  <= '0;
                pw    <= run_power;
                step  <= '0;
                state <= S_STEP;
              end
              KIND_END: begin
                run_hash  <= '0;
                run_power <= HASH_W'(1);
              end
              default: ;
            endcase
          end
        end
        S_STEP: begin
          term <= term_next;
          pw   <= pw_next;
          ch   <= {ch[CH_W-2:0], 1'b0};
          step <= step + 3'd1;
          if (step == 3'(CH_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          run_hash  <= sum_next;
          run_power <= pw;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/phbl_back.sv -----
`default_nettype none
module phbl_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int FW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic [phbl_pkg::HASH_W-1:0] q_hash,
  input  wire logic [FW-1:0]               q_count,
  output logic                             rd_en,
  output logic      [AW-1:0]               rd_addr,
  input  wire logic [phbl_pkg::HASH_W-1:0] rd_data,
  output logic                             done,
  output logic      [phbl_pkg::HASH_W-1:0] hash_value,
  output logic                             is_blocked
);
  import phbl_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t            state;
  logic [HASH_W-1:0] key;
  logic [FW-1:0]     cnt;
  logic [FW-1:0]     rd_idx;
  logic              pending;
  logic              found;

  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign rd_en   = (state == S_SCAN) && (rd_idx != cnt);
  assign rd_addr = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (q_pop) begin
            key     <= q_hash;
            cnt     <= q_count;
            rd_idx  <= '0;
            found   <= 1'b0;
            pending <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read one entry a cycle, compare it the cycle after.
          if (rd_en) begin
            rd_idx <= rd_idx + FW'(1);
          end
          pending <= rd_en;
          if (pending && (rd_data == key)) begin
            found <= 1'b1;
          end
          done <= !rd_en && !pending;
          if (!rd_en && !pending) begin
            hash_value <= key;
            is_blocked <= found;
            state      <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/poly_hash_blocklist_match.sv -----
// Channel   Handshake          Payload
// --------  -----------------  --------------------------------------
// command   start / busy       kind, byte_value, entry_hash
// result    done (1 cycle)     hash_value, is_blocked
//
// A command transaction completes on a clock edge with start high and busy low.
// Load and end-of-string transactions leave the front idle; a string byte holds busy
// through the 7-step shift-add modular multiply and the add into the running hash.
// The lookup for each end of string scans the loaded entries, one table RAM
// read per cycle; a 2-entry queue parts it from the command side, which the
// lookups stall only while that queue is full.
// rst is synchronous and empties the table, the queue and the running hash.
// Results cannot be stalled.
`default_nettype none
module poly_hash_blocklist_match #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  kind,
  input  wire logic [phbl_pkg::CH_W-1:0]   byte_value,
  input  wire logic [phbl_pkg::HASH_W-1:0] entry_hash,
  output logic                             done,
  output logic      [phbl_pkg::HASH_W-1:0] hash_value,
  output logic                             is_blocked
);
  import phbl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam int QW = HASH_W + FW;

  // front -> queue
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  logic [HASH_W-1:0] q_hash_in;
  logic [FW-1:0]     q_count_in;
  logic [QW-1:0]     q_out;

  // table RAM
  logic              tw_en;
  logic [AW-1:0]     tw_addr;
  logic [HASH_W-1:0] tw_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [HASH_W-1:0] rd_data;

  // Front: hash string bytes, append table loads, push finished strings.
  phbl_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW),
    .FW(FW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind(kind),
    .byte_value(byte_value),
    .entry_hash(entry_hash),
    .busy(busy),
    .q_full(q_full),
    .q_push(q_push),
    .q_hash(q_hash_in),
    .q_count(q_count_in),
    .tw_en(tw_en),
    .tw_addr(tw_addr),
    .tw_data(tw_data)
  );

  // Queue entries carry the hash and the table fill at end of string, so
  // later loads never show up in an earlier lookup.
  phbl_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data({q_count_in, q_hash_in}),
    .pop(q_pop),
    .pop_data(q_out),
    .full(q_full),
    .empty(q_empty)
  );

  phbl_ram #(
    .WIDTH(HASH_W),
    .DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_table (
    .clk(clk),
    .we(tw_en),
    .waddr(tw_addr),
    .wdata(tw_data),
    .re(rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Back: scan loaded entries and drive the result strobe.
  phbl_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW),
    .FW(FW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .q_hash(q_out[HASH_W-1:0]),
    .q_count(q_out[QW-1:HASH_W]),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .done(done),
    .hash_value(hash_value),
    .is_blocked(is_blocked)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_poly_hash_blocklist_match.sv -----
`timescale 1ns / 1ps
module tb_poly_hash_blocklist_match;
  import phbl_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  // Keep the table short during random traffic so each lookup stays cheap.
  localparam int RANDOM_FILL_CAP = 200;
  localparam int POOL_N = 12;
  localparam int SCRATCH = POOL_N;
  localparam int MAX_LEN = 16;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [HASH_W-1:0] HASH_BASE = 37'd128;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              blocked;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        kind = 2'd0;
  logic [CH_W-1:0]   byte_value = '0;
  logic [HASH_W-1:0] entry_hash = '0;
  logic              done;
  logic [HASH_W-1:0] hash_value;
  logic              is_blocked;

  // Mirror of the block: running hash, running power and the bad-hash table.
  logic [HASH_W-1:0] model_hash;
  logic [HASH_W-1:0] model_power;
  logic [HASH_W-1:0] model_table [TABLE_DEPTH];
  int                model_fill;

  verdict_t pending_verdicts[$];

  // Strings that are reused so that loaded digests actually get hit.
  logic [CH_W-1:0] phrase_bytes [POOL_N+1][MAX_LEN];
  int              phrase_len [POOL_N+1];

  int idle_pct = 0;
  int items_sent = 0;
  int mismatch_count = 0;
  int strings_done = 0;
  int blocked_hits = 0;
  int loads_kept = 0;
  int loads_dropped = 0;

  poly_hash_blocklist_match #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .byte_value(byte_value),
    .entry_hash(entry_hash),
    .done(done),
    .hash_value(hash_value),
    .is_blocked(is_blocked)
  );

  always #10 clk = ~clk;

  function automatic logic [HASH_W-1:0] rand37();
    return {5'($urandom), $urandom};
  endfunction

  function automatic logic [HASH_W-1:0] mulmod(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
    return HASH_W'((64'(a) * 64'(b)) % 64'(HASH_MOD));
  endfunction

  function automatic logic [HASH_W-1:0] addmod(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
    return HASH_W'((64'(a) + 64'(b)) % 64'(HASH_MOD));
  endfunction

  // Hash a pooled string from scratch, for loading it as a bad entry.
  function automatic logic [HASH_W-1:0] phrase_digest(input int idx);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] p;
    h = '0;
    p = 37'd1;
    for (int i = 0; i < phrase_len[idx]; i++) begin
      h = addmod(h, mulmod(HASH_W'(phrase_bytes[idx][i]), p));
      p = mulmod(p, HASH_BASE);
    end
    return h;
  endfunction

  function automatic logic table_has(input logic [HASH_W-1:0] h);
    for (int k = 0; k < model_fill; k++) begin
      if (model_table[k] == h) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the mirror by one accepted transaction; queue the verdict on end of string.
  function automatic void absorb_command(input logic [1:0] k, input logic [CH_W-1:0] b,
                                         input logic [HASH_W-1:0] e);
    verdict_t v;
    case (k)
      KIND_LOAD: begin
        if (model_fill < TABLE_DEPTH) begin
          model_table[model_fill] = e;
          model_fill++;
          loads_kept++;
        end else begin
          loads_dropped++;
        end
      end
      KIND_BYTE: begin
        model_hash = addmod(model_hash, mulmod(HASH_W'(b), model_power));
        model_power = mulmod(model_power, HASH_BASE);
      end
      KIND_END: begin
        v.hash = model_hash;
        v.blocked = table_has(model_hash);
        pending_verdicts.insert(pending_verdicts.size(), v);
        strings_done++;
        if (v.blocked) blocked_hits++;
        model_hash = '0;
        model_power = 37'd1;
      end
      default: ;
    endcase
  endfunction

  // Send one transaction: idle at random first, then hold start until busy is low.
  task automatic send_item(input logic [1:0] k, input logic [CH_W-1:0] b,
                           input logic [HASH_W-1:0] e);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      kind = 2'($urandom);
      byte_value = CH_W'($urandom);
      entry_hash = rand37();
    end
    @(negedge clk);
    start = 1'b1;
    kind = k;
    byte_value = b;
    entry_hash = e;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_command(k, b, e);
    if (k != KIND_SPARE) items_sent++;
  endtask

  task automatic lower_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Send a pooled string and its end marker; optionally slip one stray
  // transaction (unused kind or a table load) somewhere into the string.
  task automatic send_string(input int idx, input bit noisy);
    int slot;
    slot = noisy ? $urandom_range(0, phrase_len[idx]) : -1;
    for (int i = 0; i <= phrase_len[idx]; i++) begin
      if (i == slot) begin
        if ($urandom_range(0, 1) && model_fill < RANDOM_FILL_CAP)
          send_item(KIND_LOAD, CH_W'($urandom), rand37());
        else
          send_item(KIND_SPARE, CH_W'($urandom), rand37());
      end
      if (i < phrase_len[idx])
        send_item(KIND_BYTE, phrase_bytes[idx][i], rand37());
    end
    send_item(KIND_END, CH_W'($urandom), rand37());
  endtask

  // Hold the sender until every queued verdict has come back.
  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Cover the empty string, hash zero in the table, out-of-range loads,
  // the widest byte with power wrap-around, the unused kind, and a hit.
  task automatic test_directed_corners();
    idle_pct = 0;
    send_item(KIND_END, 7'h7f, rand37());
    send_item(KIND_LOAD, 7'h00, '0);
    send_item(KIND_END, 7'h00, '1);
    send_item(KIND_LOAD, 7'h7f, '1);
    send_item(KIND_LOAD, 7'h55, HASH_MOD);
    send_item(KIND_LOAD, 7'h2a, phrase_digest(0));
    send_string(0, 1'b1);
    send_string(1, 1'b0);
    send_item(KIND_SPARE, CH_W'($urandom), rand37());
    lower_start();
    wait_drained();
  endtask

  // Mostly well-formed strings with random content, some reused so that
  // loaded digests hit; the rest is loads and stray transactions.
  task automatic test_random_traffic(input int pct, input int quota);
    int stop_at;
    int pick;
    idle_pct = pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12 && model_fill < RANDOM_FILL_CAP) begin
        if ($urandom_range(0, 1))
          send_item(KIND_LOAD, CH_W'($urandom), phrase_digest($urandom_range(0, POOL_N - 1)));
        else
          send_item(KIND_LOAD, CH_W'($urandom), rand37());
      end else if (pick < 16) begin
        send_item(KIND_SPARE, CH_W'($urandom), rand37());
      end else if (pick < 58) begin
        send_string($urandom_range(0, POOL_N - 1), $urandom_range(0, 9) == 0);
      end else begin
        phrase_len[SCRATCH] = $urandom_range(0, 14);
        for (int i = 0; i < MAX_LEN; i++) phrase_bytes[SCRATCH][i] = CH_W'($urandom);
        send_string(SCRATCH, $urandom_range(0, 9) == 0);
      end
    end
    lower_start();
  endtask

  // Fill the table to its depth with a known digest in the last slot, drop
  // further loads, and check that lookups reach the last entry.
  task automatic test_full_table();
    idle_pct = 0;
    while (model_fill < TABLE_DEPTH - 1)
      send_item(KIND_LOAD, CH_W'($urandom), rand37());
    send_item(KIND_LOAD, CH_W'($urandom), phrase_digest(2));
    send_item(KIND_LOAD, CH_W'($urandom), phrase_digest(3));
    repeat (6) send_item(KIND_LOAD, CH_W'($urandom), rand37());
    idle_pct = 34;
    send_string(2, 1'b0);
    send_string(3, 1'b0);
    send_string(0, 1'b1);
    repeat (8) send_string($urandom_range(0, POOL_N - 1), 1'b0);
    lower_start();
  endtask

  // Compare each strobed result with the oldest queued verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result: hash %0d blocked %0b", $time, hash_value,
                 is_blocked);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (hash_value !== want.hash) begin
          $display("%0t: hash_value expected %0d actual %0d", $time, want.hash, hash_value);
          mismatch_count++;
        end
        if (is_blocked !== want.blocked) begin
          $display("%0t: is_blocked expected %0b actual %0b (hash %0d)", $time,
                   want.blocked, is_blocked, want.hash);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // Slot 0: eight widest bytes, so the power wraps past the modulus.
    // Slot 1: a zero byte then a one. The rest are random.
    phrase_len[0] = 8;
    for (int i = 0; i < MAX_LEN; i++) phrase_bytes[0][i] = 7'h7f;
    phrase_len[1] = 2;
    phrase_bytes[1][0] = 7'h00;
    phrase_bytes[1][1] = 7'h01;
    for (int p = 2; p <= POOL_N; p++) begin
      phrase_len[p] = $urandom_range(1, 10);
      for (int i = 0; i < MAX_LEN; i++) phrase_bytes[p][i] = CH_W'($urandom);
    end
    model_hash = '0;
    model_power = 37'd1;
    model_fill = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_corners();
    test_random_traffic(0, 150);
    test_random_traffic(79, 150);
    // Pause the sender until the block has nothing left in flight.
    wait_drained();
    test_random_traffic(0, 100);
    test_random_traffic(34, 150);
    wait_drained();
    test_full_table();

    // Drain, then wait out a full-table lookup for stray results.
    wait_drained();
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d transactions: %0d strings checked, %0d found in the table.",
             items_sent, strings_done, blocked_hits);
    $display("Table loads kept %0d, dropped when full %0d.", loads_kept, loads_dropped);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
